// ===== rtl/keyed_record_table_core_macros.svh =====
// Assertion macros shared by the checker of the keyed record table.
// Depends on nothing; every macro expects clk and arst_n in scope.
`ifndef KEYED_RECORD_TABLE_CORE_MACROS_SVH
`define KEYED_RECORD_TABLE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KRT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/krt_pkg.sv =====
// Shared constants, codes and port bundles of the keyed record table.
// Depends on nothing; used by every RTL file of the block.
package krt_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int DATA_W = KEY_W + VAL_W;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_MODIFY = 2'd2;
	localparam logic [1:0] OP_SEARCH = 2'd3;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_DUP  = 2'd2;
	localparam logic [1:0] STATUS_FULL = 2'd3;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] data;
	} wr_req_t;

endpackage

// ===== rtl/krt_ram.sv =====
// Record memory of the keyed record table: one {key, value} word per entry.
// Depends on krt_pkg; one write port, one read port with registered data.
module krt_ram
	import krt_pkg::*;
(
	input  logic              clk,
	input  rd_req_t           rd_req,
	input  wr_req_t           wr_req,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data <= mem[rd_req.addr];
		end
	end

endmodule

// ===== rtl/krt_seq.sv =====
// Operation sequencer of the keyed record table: scan, shift, resolve and
// result register. Depends on krt_pkg; drives the ports of krt_ram.
module krt_seq
	import krt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [KEY_W-1:0]  key,
	input  logic [VAL_W-1:0]  value,
	input  logic [IDX_W-1:0]  entry_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  found_index,
	output logic [VAL_W-1:0]  found_value,
	output logic [CNT_W-1:0]  entry_count,
	output logic              changed,
	output rd_req_t           rd_req,
	output wr_req_t           wr_req,
	input  logic [DATA_W-1:0] rd_data
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SCAN    = 2'd1;
	localparam logic [1:0] ST_SHIFT   = 2'd2;
	localparam logic [1:0] ST_RESOLVE = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             dirty_q;
	logic             out_valid_q;
	logic             hit_q;
	logic             err_q;
	logic             v_s1;
	logic [IDX_W-1:0] addr_s1;

	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] fidx_q;
	logic [VAL_W-1:0] fval_q;

	logic             walking;
	logic             issue;
	logic             walk_done;
	logic             match;
	logic             out_free;
	logic             full;
	logic             bad_index;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;

	logic [1:0]       res_status;
	logic             res_wr;
	logic [IDX_W-1:0] res_addr;
	logic [CNT_W-1:0] res_count;
	logic             res_dirty;
	logic [IDX_W-1:0] res_fidx;
	logic [VAL_W-1:0] res_fval;

	assign walking   = (state_q == ST_SCAN) || (state_q == ST_SHIFT);
	assign issue     = walking && (ptr_q < count_q);
	assign walk_done = !issue && !v_s1;
	assign rd_key    = rd_data[DATA_W-1:VAL_W];
	assign rd_val    = rd_data[VAL_W-1:0];
	assign match     = (state_q == ST_SCAN) && v_s1 && (rd_key == key_q)
		&& !((op_q == OP_MODIFY) && (addr_s1 == idx_q));
	assign out_free  = !out_valid_q || out_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign bad_index = ((kind == OP_REMOVE) || (kind == OP_MODIFY))
		&& (CNT_W'(entry_index) >= count_q);

	assign rd_req.en   = issue;
	assign rd_req.addr = ptr_q[IDX_W-1:0];

	// Decide the outcome once the walk is over.
	always_comb begin
		res_status = STATUS_OK;
		res_wr     = 1'b0;
		res_addr   = idx_q;
		res_count  = count_q;
		res_dirty  = dirty_q;
		res_fidx   = '0;
		res_fval   = '0;
		if (err_q) begin
			res_status = STATUS_MISS;
		end else begin
			unique case (op_q)
				OP_ADD: begin
					if (hit_q) begin
						res_status = STATUS_DUP;
					end else if (full) begin
						res_status = STATUS_FULL;
					end else begin
						res_wr    = 1'b1;
						res_addr  = count_q[IDX_W-1:0];
						res_count = count_q + CNT_W'(1);
						res_dirty = 1'b1;
					end
				end
				OP_REMOVE: begin
					res_count = count_q - CNT_W'(1);
					res_dirty = 1'b1;
				end
				OP_MODIFY: begin
					if (hit_q) begin
						res_status = STATUS_DUP;
					end else begin
						res_wr    = 1'b1;
						res_dirty = 1'b1;
					end
				end
				OP_SEARCH: begin
					if (hit_q) begin
						res_fidx = hit_idx_q;
						res_fval = hit_val_q;
					end else begin
						res_status = STATUS_MISS;
					end
				end
				default: begin
					res_status = STATUS_MISS;
				end
			endcase
		end
	end

	// Shift moves entry i+1 down to i; resolve writes an added or modified record.
	always_comb begin
		wr_req.en   = 1'b0;
		wr_req.addr = res_addr;
		wr_req.data = {key_q, val_q};
		if ((state_q == ST_SHIFT) && v_s1) begin
			wr_req.en   = 1'b1;
			wr_req.addr = addr_s1 - IDX_W'(1);
			wr_req.data = rd_data;
		end else if ((state_q == ST_RESOLVE) && out_free) begin
			wr_req.en = res_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			count_q     <= '0;
			dirty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			err_q       <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						hit_q <= 1'b0;
						err_q <= bad_index;
						if (bad_index) begin
							state_q <= ST_RESOLVE;
						end else if (kind == OP_REMOVE) begin
							ptr_q   <= CNT_W'(entry_index) + CNT_W'(1);
							state_q <= ST_SHIFT;
						end else begin
							ptr_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_RESOLVE;
					end else if (walk_done) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_SHIFT: begin
					if (walk_done) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (out_free) begin
						count_q     <= res_count;
						dirty_q     <= res_dirty;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q[IDX_W-1:0];
		if ((state_q == ST_IDLE) && in_valid) begin
			op_q  <= kind;
			key_q <= key;
			val_q <= value;
			idx_q <= entry_index;
		end
		if (match) begin
			hit_idx_q <= addr_s1;
			hit_val_q <= rd_val;
		end
		if ((state_q == ST_RESOLVE) && out_free) begin
			status_q <= res_status;
			fidx_q   <= res_fidx;
			fval_q   <= res_fval;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = fidx_q;
	assign found_value = fval_q;
	assign entry_count = count_q;
	assign changed     = dirty_q;

endmodule

// ===== rtl/keyed_record_table_core.sv =====
// Top level of the keyed record table: sequencer plus record memory.
// Depends on krt_pkg, krt_ram and krt_seq.
//
// A packed table of up to 64 unique (key, value) records in insertion
// order. One item is in flight at a time: in_ready is high only while the
// sequencer is idle, and the result sits in an output register so the next
// item can be accepted while that result waits for its transfer. The single
// read port of the record memory walks one entry per cycle: an add, modify
// or search scans the entries from index 0 up to the count, stopping early
// when a search or duplicate check hits; a remove shifts every entry above
// entry_index down by one; and a remove or modify with an index not below
// count skips the walk and goes straight to the result. The memory has no
// reset and needs no clearing pass: entries at or above the count are never
// read, so the block accepts items right after reset.
module keyed_record_table_core
	import krt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [KEY_W-1:0]  key,
	input  logic [VAL_W-1:0]  value,
	input  logic [IDX_W-1:0]  entry_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  found_index,
	output logic [VAL_W-1:0]  found_value,
	output logic [CNT_W-1:0]  entry_count,
	output logic              changed
);

	rd_req_t           rd_req;
	wr_req_t           wr_req;
	logic [DATA_W-1:0] rd_data;

	// Sequencer: walks the table for duplicate checks, searches and shifts.
	krt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.key         (key),
		.value       (value),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_index (found_index),
		.found_value (found_value),
		.entry_count (entry_count),
		.changed     (changed),
		.rd_req      (rd_req),
		.wr_req      (wr_req),
		.rd_data     (rd_data)
	);

	// Record memory: key in the upper half of each word, value in the lower.
	krt_ram u_ram (
		.clk     (clk),
		.rd_req  (rd_req),
		.wr_req  (wr_req),
		.rd_data (rd_data)
	);

endmodule

// ===== rtl/krt_checker.sv =====
// Port-level checker of the keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table_core_macros.svh.
`include "keyed_record_table_core_macros.svh"

module krt_checker
	import krt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       status,
	input logic [IDX_W-1:0] found_index,
	input logic [VAL_W-1:0] found_value,
	input logic [CNT_W-1:0] entry_count,
	input logic             changed
);

	`KRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_value) && $stable(entry_count), "result changed while stalled")
	`KRT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a second item while busy")
	`KRT_ASSERT_NOW(a_full_count, out_valid && (status == STATUS_FULL), (entry_count == CNT_W'(DEPTH)) && !(found_index != '0), "full reported below capacity")
	`KRT_ASSERT_NOW(a_miss_zero, out_valid && (status != STATUS_OK), (found_index == '0) && (found_value == '0), "found fields set on failure")
	`KRT_ASSERT_NEXT(a_changed_sticky, changed, changed, "modified flag cleared")

endmodule

bind keyed_record_table_core krt_checker u_krt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found_index (found_index),
	.found_value (found_value),
	.entry_count (entry_count),
	.changed     (changed)
);

// ===== tb/tb_keyed_record_table_core.sv =====
// Self-checking bench for keyed_record_table_core: add, remove, modify and search transfers
// checked against an in-bench model of the record table. Depends on krt_pkg and the core RTL.
module tb_keyed_record_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import krt_pkg::*;

	localparam int RANDOM_ITEMS = 680;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 300;
	localparam int TAIL_CYCLES  = 80;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [1:0]       st;
		logic [IDX_W-1:0] fidx;
		logic [VAL_W-1:0] fval;
		logic [CNT_W-1:0] cnt;
		logic             chg;
	} table_reply_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		logic [IDX_W-1:0] idx;
		bit               has_exp;
		table_reply_t     res;
	} stim_row_t;

	typedef enum logic [1:0] {PH_FILL, PH_FULL, PH_DRAIN, PH_CHURN} fill_phase_e;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	logic             in_ready;
	logic [1:0]       kind        = OP_ADD;
	logic [KEY_W-1:0] key         = '0;
	logic [VAL_W-1:0] value       = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic             out_valid;
	logic             out_ready   = 1'b0;
	logic [1:0]       status;
	logic [IDX_W-1:0] found_index;
	logic [VAL_W-1:0] found_value;
	logic [CNT_W-1:0] entry_count;
	logic             changed;

	// shadow of the record table, advanced at every accepted input transfer
	logic [KEY_W-1:0] tbl_key [DEPTH];
	logic [VAL_W-1:0] tbl_val [DEPTH];
	int               tbl_count = 0;
	logic             tbl_dirty = 1'b0;

	table_reply_t     awaited_replies[$];
	stim_row_t        plan[$];
	int               items_in = 0;
	int               n_errors = 0;

	keyed_record_table_core dut (.*);

	always #1 clk = ~clk;

	function automatic int key_position(logic [KEY_W-1:0] k);
		int i;
		for (i = 0; i < tbl_count; i++)
			if (tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	// Apply one operation to the shadow table and return the reply it should give.
	function automatic table_reply_t table_apply(logic [1:0] op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, logic [IDX_W-1:0] idx);
		table_reply_t res;
		int           hit;
		int           i;
		res = '0;
		res.st = STATUS_OK;
		case (op)
			OP_ADD: begin
				// duplicate check wins over the full check
				if (key_position(k) >= 0)
					res.st = STATUS_DUP;
				else if (tbl_count >= DEPTH)
					res.st = STATUS_FULL;
				else begin
					tbl_key[tbl_count] = k;
					tbl_val[tbl_count] = v;
					tbl_count++;
					tbl_dirty = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (int'(idx) >= tbl_count)
					res.st = STATUS_MISS;
				else begin
					for (i = int'(idx); i < tbl_count - 1; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_val[i] = tbl_val[i + 1];
					end
					tbl_count--;
					tbl_dirty = 1'b1;
				end
			end
			OP_MODIFY: begin
				if (int'(idx) >= tbl_count)
					res.st = STATUS_MISS;
				else begin
					// keeping its own key is no duplicate
					hit = (k == tbl_key[idx]) ? -1 : key_position(k);
					if (hit >= 0 && hit != int'(idx))
						res.st = STATUS_DUP;
					else begin
						tbl_key[idx] = k;
						tbl_val[idx] = v;
						tbl_dirty = 1'b1;
					end
				end
			end
			default: begin
				// search by key
				hit = key_position(k);
				if (hit >= 0) begin
					res.fidx = IDX_W'(hit);
					res.fval = tbl_val[hit];
				end else
					res.st = STATUS_MISS;
			end
		endcase
		res.cnt = CNT_W'(tbl_count);
		res.chg = tbl_dirty;
		return res;
	endfunction

	function automatic stim_row_t mk_row(logic [1:0] op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, logic [IDX_W-1:0] idx, bit typed = 1'b0,
			logic [1:0] st = STATUS_OK, int cnt = 0, logic chg = 1'b1,
			logic [IDX_W-1:0] fi = '0, logic [VAL_W-1:0] fv = '0);
		stim_row_t r;
		r.kind    = op;
		r.key     = k;
		r.val     = v;
		r.idx     = idx;
		r.has_exp = typed;
		r.res     = '{st, fi, fv, CNT_W'(cnt), chg};
		return r;
	endfunction

	// mostly back to back, sometimes a short gap, rarely a long pause
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic bit calm_stretch();
		return (items_in % 160) >= 120;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(int pct_held);
		int roll;
		roll = $urandom_range(0, 99);
		if (tbl_count > 0 && roll < pct_held)
			return tbl_key[$urandom_range(0, tbl_count - 1)];
		if (roll >= 95) begin
			case ($urandom_range(0, 3))
				0:       return 32'h0000_0000;
				1:       return 32'hffff_ffff;
				2:       return 32'h8000_0000;
				default: return 32'h7fff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		if (tbl_count > 0 && $urandom_range(0, 99) < 80)
			return IDX_W'($urandom_range(0, tbl_count - 1));
		return IDX_W'($urandom_range(0, DEPTH - 1));
	endfunction

	// Well-formed traffic: the phase biases the mix so the table fills, sits full, drains and churns.
	function automatic stim_row_t build_item(fill_phase_e ph);
		stim_row_t r;
		int        roll;
		int        add_pct;
		int        rem_pct;
		int        mod_pct;
		case (ph)
			PH_FILL:  begin add_pct = 75; rem_pct = 5;  mod_pct = 10; end
			PH_FULL:  begin add_pct = 60; rem_pct = 0;  mod_pct = 10; end
			PH_DRAIN: begin add_pct = 10; rem_pct = 70; mod_pct = 10; end
			default:  begin add_pct = 35; rem_pct = 25; mod_pct = 20; end
		endcase
		r         = '0;
		r.key     = $urandom();
		r.val     = $urandom();
		r.idx     = pick_index();
		roll      = $urandom_range(0, 99);
		if (roll < add_pct) begin
			r.kind = OP_ADD;
			r.key  = pick_key(ph == PH_FULL ? 50 : 10);
		end else if (roll < add_pct + rem_pct)
			r.kind = OP_REMOVE;
		else if (roll < add_pct + rem_pct + mod_pct) begin
			r.kind = OP_MODIFY;
			if ($urandom_range(0, 9) < 3 && int'(r.idx) < tbl_count)
				r.key = tbl_key[r.idx];
			else
				r.key = pick_key(30);
		end else begin
			r.kind = OP_SEARCH;
			r.key  = pick_key(70);
		end
		return r;
	endfunction

	// Offer one item, hold it until the transfer, then queue its reply.
	task automatic offer(input stim_row_t r);
		table_reply_t want;
		int           gap;
		gap = calm_stretch() ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= r.kind;
		key         <= r.key;
		value       <= r.val;
		entry_index <= r.idx;
		do @(posedge clk); while (!in_ready);
		want = table_apply(r.kind, r.key, r.val, r.idx);
		if (r.has_exp)
			want = r.res;
		awaited_replies.push_back(want);
		items_in <= items_in + 1;
	endtask

	initial begin : stimulus
		fill_phase_e ph;
		int          ph_left;
		int          n;

		// directed table: empty-table errors, key extremes, duplicates and the shift on remove
		plan.push_back(mk_row(OP_SEARCH, 32'h0000_0000, 32'h0, 6'd0, 1, STATUS_MISS, 0, 0));
		plan.push_back(mk_row(OP_REMOVE, 32'h0000_0000, 32'h0, 6'd0, 1, STATUS_MISS, 0, 0));
		plan.push_back(mk_row(OP_MODIFY, 32'hffff_ffff, 32'hffff_ffff, 6'd63, 1,
			STATUS_MISS, 0, 0));
		plan.push_back(mk_row(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 6'd0, 1, STATUS_OK, 1));
		plan.push_back(mk_row(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 6'd0, 1, STATUS_OK, 2));
		plan.push_back(mk_row(OP_ADD, 32'h0000_0000, 32'h0000_0000, 6'd0, 1, STATUS_OK, 3));
		plan.push_back(mk_row(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 6'd0, 1, STATUS_OK, 4));
		plan.push_back(mk_row(OP_ADD, 32'h8000_0000, 32'h1, 6'd0, 1, STATUS_DUP, 4));
		plan.push_back(mk_row(OP_SEARCH, 32'h8000_0000, 32'h0, 6'd0, 1, STATUS_OK, 4, 1,
			6'd0, 32'h7fff_ffff));
		plan.push_back(mk_row(OP_SEARCH, 32'hffff_ffff, 32'h0, 6'd0, 1, STATUS_OK, 4, 1,
			6'd3, 32'hffff_ffff));
		plan.push_back(mk_row(OP_SEARCH, 32'h1234_5678, 32'h0, 6'd0, 1, STATUS_MISS, 4));
		plan.push_back(mk_row(OP_MODIFY, 32'h7fff_ffff, 32'h5555_aaaa, 6'd1, 1, STATUS_OK, 4));
		plan.push_back(mk_row(OP_MODIFY, 32'h8000_0000, 32'h0, 6'd2, 1, STATUS_DUP, 4));
		plan.push_back(mk_row(OP_MODIFY, 32'h1, 32'h1, 6'd4, 1, STATUS_MISS, 4));
		plan.push_back(mk_row(OP_MODIFY, 32'h2aaa_aaaa, 32'haaaa_5555, 6'd2, 1, STATUS_OK, 4));
		plan.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0, 6'd63, 1, STATUS_MISS, 4));
		plan.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0, 6'd0, 1, STATUS_OK, 3));
		plan.push_back(mk_row(OP_SEARCH, 32'h7fff_ffff, 32'h0, 6'd0, 1, STATUS_OK, 3, 1,
			6'd0, 32'h5555_aaaa));
		plan.push_back(mk_row(OP_SEARCH, 32'h2aaa_aaaa, 32'h0, 6'd0));
		plan.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0, 6'd2, 1, STATUS_OK, 2));
		plan.push_back(mk_row(OP_SEARCH, 32'hffff_ffff, 32'h0, 6'd0));
		plan.push_back(mk_row(OP_MODIFY, 32'h8000_0000, 32'h0, 6'd0));
		plan.push_back(mk_row(OP_REMOVE, 32'h0, 32'h0, 6'd0));
		plan.push_back(mk_row(OP_SEARCH, 32'h2aaa_aaaa, 32'h0, 6'd0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer(plan[i]);

		ph      = PH_FILL;
		ph_left = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			case (ph)
				PH_FILL:
					if (tbl_count >= DEPTH) begin
						ph      = PH_FULL;
						ph_left = 12;
					end
				PH_FULL:
					if (ph_left <= 0)
						ph = PH_DRAIN;
				PH_DRAIN:
					if (tbl_count == 0) begin
						ph      = PH_CHURN;
						ph_left = 80;
					end
				default:
					if (ph_left <= 0)
						ph = PH_FILL;
			endcase
			ph_left--;
			offer(build_item(ph));
		end
		in_valid <= 1'b0;

		// drain outstanding replies, then watch for strays
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Output side: random stalls, calm stretches, and one long hold so the input backs up.
	initial begin : reply_sink
		int stall;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_in >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm_stretch()) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = idle_len();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : reply_check
		table_reply_t got;
		table_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, found_index, found_value, entry_count, changed};
			if (awaited_replies.size() == 0) begin
				n_errors++;
				if (n_errors <= REPORT_MAX)
					$display("unexpected reply: st=%0d idx=%0d val=%h cnt=%0d chg=%0d",
						got.st, got.fidx, got.fval, got.cnt, got.chg);
			end else begin
				want = awaited_replies.pop_front();
				if (got.st !== want.st || got.fidx !== want.fidx || got.fval !== want.fval
						|| got.cnt !== want.cnt || got.chg !== want.chg) begin
					n_errors++;
					if (n_errors <= REPORT_MAX)
						$display({"reply mismatch: exp st=%0d idx=%0d val=%h cnt=%0d chg=%0d",
							" / got st=%0d idx=%0d val=%h cnt=%0d chg=%0d"},
							want.st, want.fidx, want.fval, want.cnt, want.chg,
							got.st, got.fidx, got.fval, got.cnt, got.chg);
				end
			end
		end
	end

	initial begin : watchdog
		#1_500_000;
		$display("status: fail");
		$finish;
	end

endmodule
